// ----- src/sicrd_pkg.sv -----
// shared types and constants for the signed integer to radix digit block
// no dependencies
package sicrd_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int SYM_W       = 8;
    localparam int NUM_W       = 32;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int CNT_W       = 6;
    localparam int BUF_DEPTH   = 32;
    localparam int BUF_IDX_W   = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;

    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SPACE_LO  = 8'd9;
    localparam logic [SYM_W-1:0] SPACE_HI  = 8'd13;

    // register index taken from paddr[4:3]
    localparam logic [1:0] REG_BASE_LEN = 2'd0;
    localparam logic [1:0] REG_SYM_LO   = 2'd1;
    localparam logic [1:0] REG_SYM_HI   = 2'd2;

    localparam logic [RADIX_W-1:0]    RST_BASE_LEN = 5'd10;
    localparam logic [CFG_DATA_W-1:0] RST_SYM_LO   = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] RST_SYM_HI   = 64'h0000_0000_0000_3938;

    // floor(2^32 / radix), radix 0 and 1 never used
    localparam logic [NUM_W-1:0] RECIP [17] = '{
        32'd0,
        32'd0,
        32'((64'd1 << 32) / 64'd2),
        32'((64'd1 << 32) / 64'd3),
        32'((64'd1 << 32) / 64'd4),
        32'((64'd1 << 32) / 64'd5),
        32'((64'd1 << 32) / 64'd6),
        32'((64'd1 << 32) / 64'd7),
        32'((64'd1 << 32) / 64'd8),
        32'((64'd1 << 32) / 64'd9),
        32'((64'd1 << 32) / 64'd10),
        32'((64'd1 << 32) / 64'd11),
        32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd13),
        32'((64'd1 << 32) / 64'd14),
        32'((64'd1 << 32) / 64'd15),
        32'((64'd1 << 32) / 64'd16)
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

// ----- src/sicrd_if.sv -----
// handshake channels for the number input and the symbol output
// depends on sicrd_pkg
interface sicrd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sicrd_pkg::NUM_W-1:0]   number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface sicrd_out_if;
    logic                          valid;
    logic                          ready;
    logic [sicrd_pkg::SYM_W-1:0]   symbol;
    logic                          last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ----- src/sicrd_tbl_chk.sv -----
// symbol table check: length range, forbidden bytes and duplicates
// depends on sicrd_pkg
module sicrd_tbl_chk #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic [sicrd_pkg::RADIX_W-1:0]                    i_len,
    input  logic [sicrd_pkg::NUM_SLOTS*sicrd_pkg::SYM_W-1:0] i_syms,
    output logic                                             o_ok
);

    logic [sicrd_pkg::NUM_SLOTS-1:0] in_use;
    logic [sicrd_pkg::NUM_SLOTS-1:0] bad;
    logic                            len_ok;

    always_comb begin
        logic [sicrd_pkg::SYM_W-1:0] s;
        for (int i = 0; i < sicrd_pkg::NUM_SLOTS; i++) begin
            in_use[i] = (i_len > sicrd_pkg::RADIX_W'(i));
        end
        for (int i = 0; i < sicrd_pkg::NUM_SLOTS; i++) begin
            s = i_syms[i*sicrd_pkg::SYM_W +: sicrd_pkg::SYM_W];
            bad[i] = in_use[i] && ((s == sicrd_pkg::SYM_PLUS) || (s == sicrd_pkg::SYM_MINUS)
                     || ((s >= sicrd_pkg::SPACE_LO) && (s <= sicrd_pkg::SPACE_HI)));
            for (int j = i + 1; j < sicrd_pkg::NUM_SLOTS; j++) begin
                if (in_use[j] && (i_syms[j*sicrd_pkg::SYM_W +: sicrd_pkg::SYM_W] == s)) begin
                    bad[i] = 1'b1;
                end
            end
        end
        len_ok = (i_len >= 5'd2) && (i_len <= sicrd_pkg::RADIX_W'(MAX_SYMBOLS));
        o_ok   = len_ok && (bad == '0);
    end

endmodule

// ----- src/signed_int_to_custom_radix_digits.sv -----
// top level: config registers, digit sequencer and output word register
// depends on sicrd_pkg, sicrd_if and sicrd_tbl_chk
//
// usage
// i_num carries one signed 32-bit number per word; o_sym returns its
// rendering one symbol byte per word, with last set on the final one.
// a negative number gives '-' first, then the digits most significant
// first. with an invalid symbol table a number is taken and dropped.
// the radix and symbol table are written over the apb port; the user
// must write them only while idle: the block does not enforce it.
// one shared 32x32 multiplier divides by the radix via a reciprocal
// table: S_MUL then S_DIV per digit; digits go to a 32-entry stack,
// then pop at one symbol per cycle while o_sym is not stalled. the
// sign word is valid in the cycle after accept. i_num.ready is high
// only in idle with the output register free or draining. a stalled
// receiver holds the output word and freezes the pop side. reset
// restores radix 10 and symbols "0123456789" and empties the sequencer.
module signed_int_to_custom_radix_digits #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    sicrd_in_if.sink                              i_num,
    sicrd_out_if.source                           o_sym,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sicrd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [sicrd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [sicrd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    sicrd_pkg::t_state r_state, n_state;

    logic [sicrd_pkg::RADIX_W-1:0]    r_base_len;
    logic [sicrd_pkg::CFG_DATA_W-1:0] r_sym_lo;
    logic [sicrd_pkg::CFG_DATA_W-1:0] r_sym_hi;

    logic [sicrd_pkg::NUM_W-1:0]      r_mag;
    logic [2*sicrd_pkg::NUM_W-1:0]    r_prod;
    logic [sicrd_pkg::NUM_W-1:0]      r_recip;
    logic [sicrd_pkg::RADIX_W-1:0]    r_radix;
    logic [sicrd_pkg::CNT_W-1:0]      r_cnt;
    logic [sicrd_pkg::DIGIT_W-1:0]    r_buf [sicrd_pkg::BUF_DEPTH];

    logic                             r_out_valid;
    logic [sicrd_pkg::SYM_W-1:0]      r_out_sym;
    logic                             r_out_last;

    logic                             tbl_ok;
    logic                             cfg_wr;
    logic                             out_free;
    logic                             accept;
    logic                             push;
    logic                             pop;
    logic                             load_sign;

    logic [sicrd_pkg::NUM_W-1:0]      raw;
    logic [sicrd_pkg::NUM_W-1:0]      q_est;
    logic [sicrd_pkg::NUM_W-1:0]      quot;
    logic [10:0]                      qr_full;
    logic [5:0]                       rem_est;
    logic [5:0]                       rem;
    logic                             fix;
    logic [sicrd_pkg::DIGIT_W-1:0]    digit;
    logic [sicrd_pkg::BUF_IDX_W-1:0]  pop_idx;
    logic [sicrd_pkg::DIGIT_W-1:0]    pop_digit;
    logic [2*sicrd_pkg::CFG_DATA_W-1:0] syms;

    sicrd_tbl_chk #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_tbl_chk (
        .i_len  (r_base_len),
        .i_syms (syms),
        .o_ok   (tbl_ok)
    );

    assign syms   = {r_sym_hi, r_sym_lo};
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[4:3])
            sicrd_pkg::REG_BASE_LEN: prdata = {59'd0, r_base_len};
            sicrd_pkg::REG_SYM_LO:   prdata = r_sym_lo;
            sicrd_pkg::REG_SYM_HI:   prdata = r_sym_hi;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len <= sicrd_pkg::RST_BASE_LEN;
            r_sym_lo   <= sicrd_pkg::RST_SYM_LO;
            r_sym_hi   <= sicrd_pkg::RST_SYM_HI;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                sicrd_pkg::REG_BASE_LEN: r_base_len <= pwdata[4:0];
                sicrd_pkg::REG_SYM_LO:   r_sym_lo   <= pwdata;
                sicrd_pkg::REG_SYM_HI:   r_sym_hi   <= pwdata;
                default: ;
            endcase
        end
    end

    // divide step: estimate is the true quotient or one below it
    assign raw     = i_num.number;
    assign q_est   = r_prod[2*sicrd_pkg::NUM_W-1:sicrd_pkg::NUM_W];
    assign qr_full = q_est[5:0] * r_radix;
    assign rem_est = r_mag[5:0] - qr_full[5:0];
    assign fix     = (rem_est >= {1'b0, r_radix});
    assign rem     = fix ? (rem_est - {1'b0, r_radix}) : rem_est;
    assign quot    = q_est + {31'd0, fix};
    assign digit   = rem[3:0];

    assign pop_idx   = sicrd_pkg::BUF_IDX_W'(r_cnt - 6'd1);
    assign pop_digit = r_buf[pop_idx];

    assign out_free    = !r_out_valid || o_sym.ready;
    assign i_num.ready = (r_state == sicrd_pkg::S_IDLE) && out_free;
    assign o_sym.valid  = r_out_valid;
    assign o_sym.symbol = r_out_sym;
    assign o_sym.last   = r_out_last;

    always_comb begin
        n_state   = r_state;
        accept    = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        load_sign = 1'b0;
        unique case (r_state)
            sicrd_pkg::S_IDLE: begin
                if (i_num.valid && i_num.ready) begin
                    accept = 1'b1;
                    if (tbl_ok) begin
                        load_sign = raw[sicrd_pkg::NUM_W-1];
                        n_state   = sicrd_pkg::S_MUL;
                    end
                end
            end
            sicrd_pkg::S_MUL: begin
                n_state = sicrd_pkg::S_DIV;
            end
            sicrd_pkg::S_DIV: begin
                push = 1'b1;
                if ((quot == '0) || (r_cnt == 6'd31)) begin
                    n_state = sicrd_pkg::S_EMIT;
                end else begin
                    n_state = sicrd_pkg::S_MUL;
                end
            end
            sicrd_pkg::S_EMIT: begin
                if (out_free) begin
                    pop = 1'b1;
                    if (r_cnt == 6'd1) begin
                        n_state = sicrd_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = sicrd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sicrd_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_cnt <= r_cnt + 6'd1;
            end else if (pop) begin
                r_cnt <= r_cnt - 6'd1;
            end
            if (load_sign || pop) begin
                r_out_valid <= 1'b1;
            end else if (o_sym.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag   <= raw[sicrd_pkg::NUM_W-1] ? (~raw + 32'd1) : raw;
            r_radix <= r_base_len;
            r_recip <= sicrd_pkg::RECIP[r_base_len];
        end else if (push) begin
            r_mag <= quot;
        end
        if (r_state == sicrd_pkg::S_MUL) begin
            r_prod <= r_mag * r_recip;
        end
        if (push) begin
            r_buf[r_cnt[sicrd_pkg::BUF_IDX_W-1:0]] <= digit;
        end
        if (load_sign) begin
            r_out_sym  <= sicrd_pkg::SYM_MINUS;
            r_out_last <= 1'b0;
        end else if (pop) begin
            r_out_sym  <= syms[{pop_digit, 3'b000} +: sicrd_pkg::SYM_W];
            r_out_last <= (r_cnt == 6'd1);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 6'd32)
        else $error("digit stack overflow");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sicrd_pkg::S_IDLE) |-> (r_cnt == '0))
        else $error("digit stack not empty in idle");

    a_bad_tbl_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !tbl_ok) |=> (r_state == sicrd_pkg::S_IDLE) && !r_out_valid)
        else $error("number with invalid table not dropped");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sicrd_pkg::S_DIV) |-> ({1'b0, digit} < r_radix))
        else $error("digit not below radix");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (r_cnt == 6'd1)) |=> (r_state == sicrd_pkg::S_IDLE) && r_out_last)
        else $error("last word not flagged at end of number");

endmodule

// ----- sim/tb_top.sv -----
// testbench for signed_int_to_custom_radix_digits: random and directed numbers
// against a digit predictor, apb register setup and readback, random stalls
// depends on sicrd_pkg, sicrd_if and the block's top level
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 12;
    localparam int MAX_SYMBOLS = 16;
    localparam int N_PHASES    = 26;
    localparam int HOLD_PHASE  = 22;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 120;
    localparam int QUIET_LIMIT = 3000;
    localparam int VALID_ITEMS = 18;
    localparam int DEAD_ITEMS  = 6;

    localparam logic [sicrd_pkg::CFG_DATA_W-1:0] HEX_LO = 64'h3736_3534_3332_3130;
    localparam logic [sicrd_pkg::CFG_DATA_W-1:0] HEX_HI = 64'h6665_6463_6261_3938;

    typedef struct packed {
        logic [sicrd_pkg::SYM_W-1:0] symbol;
        logic                        last;
    } t_sym_word;

    class digit_tracker;
        logic [sicrd_pkg::RADIX_W-1:0]      radix_reg;
        logic [2*sicrd_pkg::CFG_DATA_W-1:0] symbols;
        t_sym_word                          expected_symbols[$];
        int                                 errors;

        function new();
            radix_reg = sicrd_pkg::RST_BASE_LEN;
            symbols   = {sicrd_pkg::RST_SYM_HI, sicrd_pkg::RST_SYM_LO};
            errors    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [sicrd_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                sicrd_pkg::REG_BASE_LEN:
                    radix_reg = value[sicrd_pkg::RADIX_W-1:0];
                sicrd_pkg::REG_SYM_LO:
                    symbols[sicrd_pkg::CFG_DATA_W-1:0] = value;
                sicrd_pkg::REG_SYM_HI:
                    symbols[2*sicrd_pkg::CFG_DATA_W-1:sicrd_pkg::CFG_DATA_W] = value;
                default: ;
            endcase
        endfunction

        function logic [sicrd_pkg::CFG_DATA_W-1:0] reg_value(logic [1:0] idx);
            case (idx)
                sicrd_pkg::REG_BASE_LEN:
                    return {{(sicrd_pkg::CFG_DATA_W-sicrd_pkg::RADIX_W){1'b0}}, radix_reg};
                sicrd_pkg::REG_SYM_LO:
                    return symbols[sicrd_pkg::CFG_DATA_W-1:0];
                default:
                    return symbols[2*sicrd_pkg::CFG_DATA_W-1:sicrd_pkg::CFG_DATA_W];
            endcase
        endfunction

        function logic [sicrd_pkg::SYM_W-1:0] table_symbol(int idx);
            return symbols[8*idx +: 8];
        endfunction

        function bit table_ok();
            logic [sicrd_pkg::SYM_W-1:0] s;
            if (radix_reg < 2 || radix_reg > MAX_SYMBOLS) return 1'b0;
            for (int i = 0; i < int'(radix_reg); i++) begin
                s = table_symbol(i);
                if (s == sicrd_pkg::SYM_PLUS || s == sicrd_pkg::SYM_MINUS
                    || (s >= sicrd_pkg::SPACE_LO && s <= sicrd_pkg::SPACE_HI))
                    return 1'b0;
                for (int j = i + 1; j < int'(radix_reg); j++)
                    if (table_symbol(j) == s) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_number(logic [sicrd_pkg::NUM_W-1:0] n);
            logic [sicrd_pkg::NUM_W-1:0] mag;
            logic [sicrd_pkg::NUM_W-1:0] radix;
            int                          digits[$];
            if (!table_ok()) return;
            radix = {{(sicrd_pkg::NUM_W-sicrd_pkg::RADIX_W){1'b0}}, radix_reg};
            if (n[sicrd_pkg::NUM_W-1]) begin
                expected_symbols.push_back('{symbol: sicrd_pkg::SYM_MINUS, last: 1'b0});
                mag = ~n + 1'b1;
            end else begin
                mag = n;
            end
            do begin
                digits.push_front(int'(mag % radix));
                mag = mag / radix;
            end while (mag != 0);
            foreach (digits[i])
                expected_symbols.push_back('{symbol: table_symbol(digits[i]),
                                             last: (i == digits.size() - 1)});
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_symbol(logic [sicrd_pkg::SYM_W-1:0] s, logic l);
            t_sym_word exp_word;
            if (expected_symbols.size() == 0) begin
                report($sformatf("symbol %h last %b with nothing pending", s, l));
                return;
            end
            exp_word = expected_symbols.pop_front();
            if (s !== exp_word.symbol)
                report($sformatf("symbol %h, wanted %h", s, exp_word.symbol));
            if (l !== exp_word.last)
                report($sformatf("last %b, wanted %b", l, exp_word.last));
        endtask
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [sicrd_pkg::CFG_ADDR_W-1:0] paddr;
    logic [sicrd_pkg::CFG_DATA_W-1:0] pwdata;
    logic [sicrd_pkg::CFG_DATA_W-1:0] prdata;
    logic                             pready;

    sicrd_in_if  num_if ();
    sicrd_out_if sym_if ();

    digit_tracker sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;
    int holds_done    = 0;
    int quiet_cycles  = 0;

    signed_int_to_custom_radix_digits #(.MAX_SYMBOLS(MAX_SYMBOLS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (num_if),
        .o_sym   (sym_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (num_if.valid && num_if.ready)
                sb.note_number(num_if.number);
            if (sym_if.valid && sym_if.ready)
                sb.check_symbol(sym_if.symbol, sym_if.last);
            if ((num_if.valid && num_if.ready) || (sym_if.valid && sym_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        sym_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != holds_done) begin
                sym_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
            end
            sym_if.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_number(input logic [sicrd_pkg::NUM_W-1:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            num_if.valid = 1'b0;
            @(negedge i_clk);
        end
        num_if.valid  = 1'b1;
        num_if.number = n;
        do @(posedge i_clk); while (!num_if.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        num_if.valid = 1'b0;
        while (sb.expected_symbols.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx,
                             input logic [sicrd_pkg::CFG_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] idx,
                            output logic [sicrd_pkg::CFG_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 3'b000};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [2*sicrd_pkg::CFG_DATA_W-1:0] clean_symbols();
        logic [2*sicrd_pkg::CFG_DATA_W-1:0] t;
        logic [sicrd_pkg::SYM_W-1:0]        b;
        bit                                 ok;
        t = '0;
        for (int i = 0; i < 16; i++) begin
            do begin
                b  = sicrd_pkg::SYM_W'($urandom_range(255));
                ok = !(b == sicrd_pkg::SYM_PLUS || b == sicrd_pkg::SYM_MINUS
                       || (b >= sicrd_pkg::SPACE_LO && b <= sicrd_pkg::SPACE_HI));
                for (int j = 0; j < i; j++)
                    if (t[8*j +: 8] == b) ok = 1'b0;
            end while (!ok);
            t[8*i +: 8] = b;
        end
        return t;
    endfunction

    function automatic logic [sicrd_pkg::NUM_W-1:0] pick_number(int unsigned radix);
        logic [63:0]                 pw;
        logic [sicrd_pkg::NUM_W-1:0] n;
        int                          k;
        case ($urandom_range(5))
            0: n = $urandom_range(0, 40);
            1: n = -$urandom_range(1, 40);
            2: begin
                case ($urandom_range(4))
                    0: n = 32'h8000_0000;
                    1: n = 32'h7FFF_FFFF;
                    2: n = 32'hFFFF_FFFF;
                    3: n = 32'h8000_0001;
                    default: n = '0;
                endcase
            end
            3: begin
                pw = 64'd1;
                if (radix >= 2) begin
                    k = $urandom_range(1, 31);
                    while (k > 0 && pw * radix < 64'h8000_0000) begin
                        pw = pw * radix;
                        k--;
                    end
                end
                n = pw[sicrd_pkg::NUM_W-1:0] + $urandom_range(0, 2) - 1;
                if ($urandom_range(1)) n = -n;
            end
            default: n = $urandom;
        endcase
        return n;
    endfunction

    initial begin
        logic [1:0]                         reg_ids[3];
        logic [sicrd_pkg::CFG_DATA_W-1:0]   vals[3];
        logic [sicrd_pkg::CFG_DATA_W-1:0]   rd;
        logic [2*sicrd_pkg::CFG_DATA_W-1:0] t;
        logic [sicrd_pkg::NUM_W-1:0]        directed[$];
        int                                 base_v;
        int                                 pos;
        int                                 n_items;

        reg_ids       = '{sicrd_pkg::REG_BASE_LEN, sicrd_pkg::REG_SYM_LO,
                          sicrd_pkg::REG_SYM_HI};
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        num_if.valid  = 1'b0;
        num_if.number = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < N_PHASES; p++) begin
            if (p < N_PHASES / 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 88;
            end else if (p < 2 * N_PHASES / 3) begin
                send_idle_pct = 88;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            directed = {};
            vals     = '{64'd10, HEX_LO, HEX_HI};
            case (p)
                0: directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'd10,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001};
                1: begin
                    vals[0]  = 64'd16;
                    directed = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd15, 32'd16};
                end
                2: begin
                    // binary with the two outermost byte values
                    t         = clean_symbols();
                    t[15:0]   = 16'hFF00;
                    vals      = '{64'd2, t[sicrd_pkg::CFG_DATA_W-1:0],
                                  t[2*sicrd_pkg::CFG_DATA_W-1:sicrd_pkg::CFG_DATA_W]};
                    directed  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1};
                end
                // upper length bits dropped, bytes next to the forbidden ones
                3: vals = '{64'hFFFF_FFFF_FFFF_FFEF, 64'h2E2C_2A0E_08FF_7F00,
                            64'h4746_4544_4342_4130};
                4: begin
                    vals     = '{64'd10, 64'h3736_352B_3332_3130, sicrd_pkg::RST_SYM_HI};
                    directed = '{32'd0, 32'hFFFF_FFFF};
                end
                5: vals = '{64'd16, HEX_LO, 64'h0965_6463_6261_3938};
                6: vals = '{64'd15, HEX_LO, 64'h0965_6463_6261_3938};
                7: vals = '{64'd16, HEX_LO, 64'h3065_6463_6261_3938};
                8: vals[0] = 64'd0;
                9: vals[0] = 64'd1;
                10: vals[0] = 64'd17;
                11: vals[0] = 64'h3F;
                12: vals = '{64'd16, 64'h3736_3534_2D32_3130, HEX_HI};
                13: vals = '{64'd16, 64'h3736_3534_330D_3130, HEX_HI};
                default: begin
                    t = clean_symbols();
                    if (p == HOLD_PHASE) begin
                        base_v = 2;
                    end else begin
                        case ($urandom_range(4))
                            0: base_v = $urandom_range(31);
                            1: begin
                                base_v = $urandom_range(2, 16);
                                pos    = $urandom_range(base_v - 1);
                                case ($urandom_range(3))
                                    0: t[8*pos +: 8] = sicrd_pkg::SYM_PLUS;
                                    1: t[8*pos +: 8] = sicrd_pkg::SYM_MINUS;
                                    2: t[8*pos +: 8] = sicrd_pkg::SYM_W'($urandom_range(
                                           sicrd_pkg::SPACE_LO, sicrd_pkg::SPACE_HI));
                                    default: t[8*pos +: 8] =
                                        t[8*((pos + 1 + $urandom_range(base_v - 2)) % base_v) +: 8];
                                endcase
                            end
                            default: base_v = $urandom_range(2, 16);
                        endcase
                    end
                    vals[0]          = {$urandom, $urandom};
                    vals[0][sicrd_pkg::RADIX_W-1:0] = sicrd_pkg::RADIX_W'(base_v);
                    vals[1]          = t[sicrd_pkg::CFG_DATA_W-1:0];
                    vals[2]          = t[2*sicrd_pkg::CFG_DATA_W-1:sicrd_pkg::CFG_DATA_W];
                end
            endcase

            if (p != 0) begin
                wait_drained();
                for (int r = 0; r < 3; r++) apb_write(reg_ids[r], vals[r]);
                for (int r = 0; r < 3; r++) begin
                    apb_read(reg_ids[r], rd);
                    if (rd !== sb.reg_value(reg_ids[r]))
                        sb.report($sformatf("register %0d read %h, wanted %h",
                                            r, rd, sb.reg_value(reg_ids[r])));
                end
            end

            n_items = sb.table_ok() ? VALID_ITEMS : DEAD_ITEMS;
            if (p == HOLD_PHASE) hold_reqs++;
            foreach (directed[i]) send_number(directed[i]);
            repeat (n_items) send_number(pick_number(sb.radix_reg));
        end

        wait_drained();
        if (sb.errors == 0 && sb.expected_symbols.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
